>>> hdl/ccde_pkg.sv
// types and constants shared by the canvas cell delta engine
package ccde_pkg;

   localparam int CANVAS_WIDTH = 256;
   localparam int CANVAS_CELLS = 65536;

   // address and index widths
   localparam int ADDR_W = (CANVAS_CELLS > 1) ? $clog2(CANVAS_CELLS) : 1;
   localparam longint IDX_MAX = 64'd65535 * CANVAS_WIDTH + 64'd65535;
   localparam int IDX_W = $clog2(IDX_MAX + 1);

   localparam int COUNT_W = 17;
   localparam logic [COUNT_W-1:0] DELTA_LIMIT = 17'd65536;
   localparam logic [COUNT_W-1:0] LIVE_LIMIT  = 17'd131071;

   typedef enum logic [1:0] {
      CMD_DIFF        = 2'd0,
      CMD_SET         = 2'd1,
      CMD_REMOVE      = 2'd2,
      CMD_START_FRAME = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ST_SAME     = 3'd0,
      ST_ADDED    = 3'd1,
      ST_MODIFIED = 3'd2,
      ST_REMOVED  = 3'd3,
      ST_RANGE    = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] g;
      logic [7:0] r;
      logic [7:0] pad;
   } cell_type;

   typedef struct packed {
      command_type command;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [7:0]  new_a;
      logic [7:0]  new_b;
      logic [7:0]  new_g;
      logic [7:0]  new_r;
      logic [7:0]  new_pad;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [15:0]        cell_x;
      logic [15:0]        cell_y;
      logic [7:0]         out_a;
      logic [7:0]         out_b;
      logic [7:0]         out_g;
      logic [7:0]         out_r;
      logic [7:0]         out_pad;
      logic [COUNT_W-1:0] live_count;
      logic [COUNT_W-1:0] delta_total;
   } rsp_type;

endpackage

>>> hdl/canvas_cell_delta_engine.sv
// canvas cell delta engine: cell store, live count and delta count
//
// After reset the block sweeps the cell store to zero, one cell per clock, and
// holds busy high while it does. From then on busy stays low and a request
// may be issued on every clock. The cell store is read at the clock edge that
// takes the request. The following cycle evaluates the request and writes the
// cell back. The result is then registered and shows on rsp_item with
// rsp_strobe high for one cycle.
// A write to a cell is forwarded to the following request, so back-to-back
// requests to the same cell see each other. Every request taken while busy is
// low gives exactly one result; there is no way to stall the result side, so
// it must be taken as it comes.
module canvas_cell_delta_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ccde_pkg::req_type req_item,
   output logic             rsp_strobe,
   output ccde_pkg::rsp_type rsp_item
);
   import ccde_pkg::*;

   // cell store
   cell_type mem [CANVAS_CELLS];
   cell_type mem_rd_ff;

   // clearing sweep
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;

   // lookup stage
   logic              s1_valid_ff;
   req_type           s1_req_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              s1_inrange_ff;

   // last write, for forwarding
   logic              fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0] fwd_addr_ff;
   cell_type          fwd_data_ff;

   logic [COUNT_W-1:0] live_ff, live_in;
   logic [COUNT_W-1:0] delta_ff, delta_in;

   logic              rsp_strobe_ff;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   logic [IDX_W-1:0]  req_idx;
   logic              req_inrange;

   cell_type          stored;
   cell_type          incoming;
   logic              was_live, now_live;
   status_type        status;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   cell_type          wr_data;

   assign accept = start & ~clearing_ff;
   assign busy   = clearing_ff;

   assign req_idx = IDX_W'(req_item.pos_y) * IDX_W'(CANVAS_WIDTH) + IDX_W'(req_item.pos_x);
   assign req_inrange = req_idx < IDX_W'(CANVAS_CELLS);

   always_comb begin
      clearing_in   = clearing_ff;
      clear_addr_in = clear_addr_ff;
      if (clearing_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == ADDR_W'(CANVAS_CELLS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   // evaluate the looked-up request
   always_comb begin
      stored = (fwd_valid_ff && fwd_addr_ff == s1_addr_ff) ? fwd_data_ff : mem_rd_ff;
      incoming = '{a: s1_req_ff.new_a, b: s1_req_ff.new_b, g: s1_req_ff.new_g,
                   r: s1_req_ff.new_r, pad: s1_req_ff.new_pad};
      was_live = stored.g != 8'd0;
      now_live = incoming.g != 8'd0;

      status   = ST_SAME;
      live_in  = live_ff;
      delta_in = delta_ff;
      wr_en    = 1'b0;
      wr_addr  = s1_addr_ff;
      wr_data  = '0;

      if (s1_valid_ff) begin
         if (s1_req_ff.command == CMD_START_FRAME) begin
            delta_in = '0;
         end else if (!s1_inrange_ff) begin
            status = ST_RANGE;
         end else begin
            unique case (s1_req_ff.command)
               CMD_DIFF: begin
                  if (!was_live && now_live) begin
                     status = ST_ADDED;
                  end else if (was_live && !now_live) begin
                     status = ST_REMOVED;
                  end else if (was_live && now_live && stored != incoming) begin
                     status = ST_MODIFIED;
                  end
                  if (status != ST_SAME && delta_ff < DELTA_LIMIT) begin
                     delta_in = delta_ff + 1'b1;
                  end
               end
               CMD_SET: begin
                  wr_en   = 1'b1;
                  wr_data = incoming;
                  if (!was_live && now_live) begin
                     if (live_ff < LIVE_LIMIT) begin
                        live_in = live_ff + 1'b1;
                     end
                  end else if (was_live && !now_live) begin
                     if (live_ff != '0) begin
                        live_in = live_ff - 1'b1;
                     end
                  end
               end
               CMD_REMOVE: begin
                  wr_en = 1'b1;
                  if (was_live && live_ff != '0) begin
                     live_in = live_ff - 1'b1;
                  end
               end
               default: begin
                  status = ST_SAME;
               end
            endcase
         end
      end

      rsp_in.status      = status;
      rsp_in.cell_x      = s1_req_ff.pos_x;
      rsp_in.cell_y      = s1_req_ff.pos_y;
      rsp_in.out_a       = '0;
      rsp_in.out_b       = '0;
      rsp_in.out_g       = '0;
      rsp_in.out_r       = '0;
      rsp_in.out_pad     = '0;
      if (status == ST_ADDED || status == ST_MODIFIED) begin
         rsp_in.out_a   = incoming.a;
         rsp_in.out_b   = incoming.b;
         rsp_in.out_g   = incoming.g;
         rsp_in.out_r   = incoming.r;
         rsp_in.out_pad = incoming.pad;
      end
      rsp_in.live_count  = live_in;
      rsp_in.delta_total = delta_in;

      fwd_valid_in = wr_en;
   end

   // memory port: sweep writes zero, otherwise write-back of the lookup stage
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clear_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_rd_ff <= mem[req_idx[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         live_ff       <= '0;
         delta_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
         s1_valid_ff   <= accept;
         fwd_valid_ff  <= fwd_valid_in;
         live_ff       <= live_in;
         delta_ff      <= delta_in;
         rsp_strobe_ff <= s1_valid_ff;
      end
      s1_req_ff     <= req_item;
      s1_addr_ff    <= req_idx[ADDR_W-1:0];
      s1_inrange_ff <= req_inrange;
      fwd_addr_ff   <= wr_addr;
      fwd_data_ff   <= wr_data;
      rsp_ff        <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
